// File: src/mlpt_pkg.sv
// shared types and constants for the multiset linear probe table
// no dependencies
`timescale 1ns / 1ps

package mlpt_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_W          = 8;
	localparam int MULT_W         = 16;
	localparam int TOTAL_W        = 24;
	localparam int KEY_CODES      = 1 << KEY_W;

	localparam logic [MULT_W-1:0]  MULT_MAX  = {MULT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_COUNT  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_MISSING = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  key;
		logic [MULT_W-1:0] amount;
	} cmd_t;

	typedef struct packed {
		logic [MULT_W-1:0]  multiplicity;
		status_t            status;
		logic [TOTAL_W-1:0] total_count;
	} result_t;

	// one table entry as held in memory
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [MULT_W-1:0] count;
	} slot_t;

endpackage

// File: src/multiset_linear_probe_table_top.sv
// multiset linear probe table: slot memory, valid bits and probe sequencer
// depends on mlpt_pkg
`timescale 1ns / 1ps

// a beat probes 1 .. TABLE_SIZE slots from its home slot; done is registered from the
// finishing probe step; a new beat is taken only once busy is low again, since the one
//   read port of the slot memory lets one slot be looked at per cycle
// reset: valid bits, running total and control clear at once; no clearing pass,
//   slot memory contents are masked by the valid bits
// results are shown for exactly one cycle on done; the receiver cannot stall
module multiset_linear_probe_table_top
	import mlpt_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} state_t;

	state_t state_q;

	// command held for the probe
	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [MULT_W-1:0] amount_q;

	logic [IDX_W-1:0]      idx_q;     // slot whose read data is in the s1 registers
	logic [IDX_W-1:0]      n_q;       // slots already looked at before idx_q
	logic [TABLE_SIZE-1:0] used_q;    // valid bit per slot
	logic [TOTAL_W-1:0]    total_q;
	logic                  done_q;
	result_t               result_q;

	// slot memory, one synchronous read port
	slot_t mem [TABLE_SIZE];
	slot_t rd_word_s1;
	logic  rd_used_s1;

	// home slot for every key value, worked out at elaboration
	logic [IDX_W-1:0] home_tab [KEY_CODES];
	for (genvar g = 0; g < KEY_CODES; g++) begin : g_home
		assign home_tab[g] = IDX_W'(g % TABLE_SIZE);
	end

	logic                accept;
	logic [IDX_W-1:0]    idx_next;
	logic [IDX_W-1:0]    rd_addr;
	logic                hit;
	logic                empty;
	logic                last;
	logic                finish;
	logic                mem_we;
	slot_t               wr_word;
	logic [MULT_W:0]     mult_sum;
	logic [MULT_W-1:0]   mult_sat;
	logic [TOTAL_W:0]    tot_sum;
	logic [TOTAL_W-1:0]  tot_sat;
	logic                add_total;
	result_t             res_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// linear step with wrap
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
	assign rd_addr  = (state_q == ST_IDLE) ? home_tab[cmd.key] : idx_next;

	assign hit   = rd_used_s1 && (rd_word_s1.key == key_q);
	assign empty = !rd_used_s1;
	assign last  = (n_q == LAST_IDX);

	// saturating merge and total
	assign mult_sum = {1'b0, rd_word_s1.count} + {1'b0, amount_q};
	assign mult_sat = mult_sum[MULT_W] ? MULT_MAX : mult_sum[MULT_W-1:0];
	assign tot_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(amount_q);
	assign tot_sat  = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

	always_comb begin
		finish    = 1'b0;
		mem_we    = 1'b0;
		add_total = 1'b0;
		wr_word   = '{key: key_q, count: amount_q};
		res_d     = '{multiplicity: '0, status: STATUS_OK, total_count: total_q};
		if (state_q == ST_PROBE) begin
			if (hit) begin
				finish = 1'b1;
				if (func_q == FUNC_INSERT) begin
					mem_we        = 1'b1;
					add_total     = 1'b1;
					wr_word.count = mult_sat;
					res_d.multiplicity = mult_sat;
				end else begin
					res_d.multiplicity = rd_word_s1.count;
				end
			end else if (empty) begin
				// probe ends on the first free slot
				finish = 1'b1;
				if (func_q == FUNC_INSERT) begin
					mem_we    = 1'b1;
					add_total = 1'b1;
					res_d.multiplicity = amount_q;
				end else begin
					res_d.status = STATUS_MISSING;
				end
			end else if (last) begin
				// every slot looked at, key not there
				finish = 1'b1;
				res_d.status = (func_q == FUNC_INSERT) ? STATUS_FULL : STATUS_MISSING;
			end
			if (add_total) begin
				res_d.total_count = tot_sat;
			end
		end
	end

	// a write lands on the finishing edge and the next command's read comes on a later edge
	// at the earliest, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= wr_word;
		end
		rd_word_s1 <= mem[rd_addr];
		rd_used_s1 <= used_q[rd_addr] && !(mem_we && (idx_q == rd_addr));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= cmd.func;
			key_q    <= cmd.key;
			amount_q <= cmd.amount;
		end
		if (finish) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			used_q  <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (mem_we) begin
				used_q[idx_q] <= 1'b1;
			end
			if (add_total) begin
				total_q <= tot_sat;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROBE;
						idx_q   <= home_tab[cmd.key];
						n_q     <= '0;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_next;
						n_q   <= n_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result beat is never followed by another in the next cycle
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result beats back to back");

	// every table write is reported by a result beat next cycle
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> done_q)
		else $error("table written without a result");

	// table full only when every slot is in use, and then nothing is reported stored
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STATUS_FULL) |->
			(&used_q) && (result_q.multiplicity == '0))
		else $error("full reported with a free slot");

	// the running total never goes down
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (total_q >= $past(total_q)))
		else $error("running total decreased");

	// the probe never runs past the table size
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && last) |-> finish)
		else $error("probe ran past the last slot");

endmodule

// File: test/tb.sv
// testbench for multiset_linear_probe_table_top: directed rows then random beats,
// every result checked against a table model or a fixed row's value; depends on mlpt_pkg
`timescale 1ns / 1ps

module tb;
	import mlpt_pkg::*;

	localparam int SLOTS    = TABLE_SIZE_DEF;
	localparam int RAND_N   = 900;
	localparam int N_REPORT = 10;
	localparam int DRAIN    = 4 * (SLOTS + 1);

	// one row of the directed table; fixed rows carry a hand-typed result
	typedef struct {
		func_t       func;
		logic [7:0]  key;
		logic [15:0] amount;
		bit          fixed;
		logic [15:0] mult;
		status_t     status;
		logic [23:0] total;
	} stim_row_t;

	localparam int DIR_N = 25;

	stim_row_t dir_rows [0:DIR_N-1] = '{
		// empty table after reset
		'{FUNC_COUNT,  8'd0,   16'd0,     1'b1, 16'd0,     STATUS_MISSING, 24'd0},
		// largest amount, then a merge that saturates the multiplicity
		'{FUNC_INSERT, 8'd255, 16'hFFFF,  1'b1, 16'hFFFF,  STATUS_OK,      24'd65535},
		'{FUNC_INSERT, 8'd255, 16'd1,     1'b1, 16'hFFFF,  STATUS_OK,      24'd65536},
		// new key with zero amount still claims a slot and is then found
		'{FUNC_INSERT, 8'd0,   16'd0,     1'b1, 16'd0,     STATUS_OK,      24'd65536},
		'{FUNC_COUNT,  8'd0,   16'hFFFF,  1'b1, 16'd0,     STATUS_OK,      24'd65536},
		// collisions on home slot 0
		'{FUNC_INSERT, 8'd16,  16'h8001,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd32,  16'h7FFE,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		// home slot 15 taken, probe wraps round to slot 3
		'{FUNC_INSERT, 8'd15,  16'd3,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_COUNT,  8'd15,  16'd0,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		// absent key, probe stops at the first empty slot
		'{FUNC_COUNT,  8'd48,  16'd0,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		// fill the rest of the table
		'{FUNC_INSERT, 8'd4,   16'd12,    1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd5,   16'h5555,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd6,   16'hAAAA,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd7,   16'd1,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd8,   16'h0F0F,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd9,   16'hF0F0,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd10,  16'd100,   1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd11,  16'd0,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd12,  16'h1234,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd13,  16'h8000,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_INSERT, 8'd14,  16'h7FFF,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		// table full: new key refused, absent key probes every slot
		'{FUNC_INSERT, 8'd100, 16'd9,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_COUNT,  8'd200, 16'd0,     1'b0, 16'd0,     STATUS_OK,      24'd0},
		// merge into an existing key still works when full
		'{FUNC_INSERT, 8'd4,   16'hFFFF,  1'b0, 16'd0,     STATUS_OK,      24'd0},
		'{FUNC_COUNT,  8'd255, 16'd0,     1'b0, 16'd0,     STATUS_OK,      24'd0}
	};

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	multiset_linear_probe_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// model of the table, updated once per accepted beat
	bit          tbl_used  [SLOTS];
	logic [7:0]  tbl_key   [SLOTS];
	logic [15:0] tbl_count [SLOTS];
	logic [23:0] running_sum;

	// results still owed by the block, oldest first
	result_t pending_results[$];

	// hand-typed expectation travelling with the beat being offered
	bit      row_fixed;
	result_t row_want;

	int n_mismatch;
	int n_results;
	int n_full;
	int n_missing;
	int n_mult_sat;
	int n_total_sat;
	bit calm;

	// probe and update the model table; returns the result the block should give
	function automatic result_t apply_to_table(cmd_t c);
		int      idx;
		int      pos;
		int      sum;
		bit      hit;
		bit      has_free;
		result_t r;
		idx      = c.key % SLOTS;
		pos      = 0;
		hit      = 1'b0;
		has_free = 1'b0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!tbl_used[idx]) begin
				has_free = 1'b1;
				pos      = idx;
				break;
			end
			if (tbl_key[idx] == c.key) begin
				hit = 1'b1;
				pos = idx;
				break;
			end
			idx = (idx + 1) % SLOTS;
		end
		r.multiplicity = '0;
		r.status       = STATUS_OK;
		if (c.func == FUNC_INSERT) begin
			if (hit || has_free) begin
				sum = hit ? int'(tbl_count[pos]) + int'(c.amount) : int'(c.amount);
				tbl_count[pos] = (sum > int'(MULT_MAX)) ? MULT_MAX : sum[15:0];
				tbl_used[pos]  = 1'b1;
				tbl_key[pos]   = c.key;
				r.multiplicity = tbl_count[pos];
				// total takes the full amount even when the slot is saturated
				sum = int'(running_sum) + int'(c.amount);
				running_sum = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : sum[23:0];
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (hit) begin
			r.multiplicity = tbl_count[pos];
		end else begin
			r.status = STATUS_MISSING;
		end
		r.total_count = running_sum;
		return r;
	endfunction

	// offer one beat after an idle gap, hold it until the block takes it
	task automatic send_beat(input cmd_t c, input bit fixed, input result_t want,
		input int gap);
		if (gap > 0) begin
			start     = 1'b0;
			row_fixed = 1'b0;
			// junk on the command bus while idle, the block must ignore it
			repeat (gap) begin
				cmd = cmd_t'($urandom);
				@(negedge clk);
			end
		end
		cmd       = c;
		row_fixed = fixed;
		row_want  = want;
		start     = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 12));
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// sample at the rising edge: check results, then log accepted beats
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (done === 1'b1) begin
				n_results++;
				if (pending_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= N_REPORT)
						$display("unexpected result at %0t: mult %0d status %0d total %0d",
							$realtime, result.multiplicity, result.status,
							result.total_count);
				end else begin
					exp_r = pending_results.pop_front();
					if (result.multiplicity !== exp_r.multiplicity ||
						result.status !== exp_r.status ||
						result.total_count !== exp_r.total_count) begin
						n_mismatch++;
						if (n_mismatch <= N_REPORT) begin
							$write("mismatch at %0t: expected mult %0d status %0d total %0d, ",
								$realtime, exp_r.multiplicity, exp_r.status,
								exp_r.total_count);
							$display("got mult %0d status %0d total %0d",
								result.multiplicity, result.status, result.total_count);
						end
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				exp_r = apply_to_table(cmd);
				if (row_fixed)
					exp_r = row_want;
				if (exp_r.status == STATUS_FULL)
					n_full++;
				if (exp_r.status == STATUS_MISSING)
					n_missing++;
				if (cmd.func == FUNC_INSERT && exp_r.status == STATUS_OK &&
					exp_r.multiplicity == MULT_MAX)
					n_mult_sat++;
				if (exp_r.total_count == TOTAL_MAX)
					n_total_sat++;
				pending_results.push_back(exp_r);
			end
		end
	end

	// stimulus
	initial begin
		cmd_t    c;
		result_t want;
		int      pick;
		int      slot;
		int      waited;
		start       = 1'b0;
		cmd         = '0;
		arst_n      = 1'b0;
		row_fixed   = 1'b0;
		row_want    = '0;
		running_sum = '0;
		calm        = 1'b0;
		n_mismatch  = 0;
		n_results   = 0;
		n_full      = 0;
		n_missing   = 0;
		n_mult_sat  = 0;
		n_total_sat = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i]  = 1'b0;
			tbl_key[i]   = '0;
			tbl_count[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < DIR_N; i++) begin
			c.func            = dir_rows[i].func;
			c.key             = dir_rows[i].key;
			c.amount          = dir_rows[i].amount;
			want.multiplicity = dir_rows[i].mult;
			want.status       = dir_rows[i].status;
			want.total_count  = dir_rows[i].total;
			send_beat(c, dir_rows[i].fixed, want, draw_gap());
		end

		// random beats: mostly hits on stored keys, which sit at every probe
		// depth, the rest absent keys and refused new keys
		for (int i = 0; i < RAND_N; i++) begin
			// stretches of back-to-back beats now and then
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			slot = $urandom_range(0, SLOTS - 1);
			c.func = (pick < 4 || pick == 8) ? FUNC_COUNT : FUNC_INSERT;
			if (pick < 7 && tbl_used[slot])
				c.key = tbl_key[slot];
			else
				c.key = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 7))
				0: c.amount = '0;
				1: c.amount = 16'hFFFF;
				default: c.amount = 16'($urandom);
			endcase
			send_beat(c, 1'b0, '0, draw_gap());
		end
		start = 1'b0;
		cmd   = '0;

		// let the last results out
		waited = 0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN) @(posedge clk);

		if (pending_results.size() != 0) begin
			n_mismatch += pending_results.size();
			$display("%0d results never arrived", pending_results.size());
		end
		$display("%0d beats, %0d results; %0d refused as full, %0d keys absent",
			DIR_N + RAND_N, n_results, n_full, n_missing);
		$display("%0d saturated multiplicities, %0d results at saturated total, %0d mismatches",
			n_mult_sat, n_total_sat, n_mismatch);
		if (n_mismatch == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
